// ----- hdl/u8sd_pkg.sv -----
// Shared constants for the strict UTF-8 decoder.
package u8sd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;

    localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_CP_2   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4   = 21'h010000;

    localparam logic [LEN_W-1:0] SEQ_IDLE  = 3'd0;
    localparam logic [LEN_W-1:0] SEQ_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] SEQ_THREE = 3'd3;
    localparam logic [LEN_W-1:0] SEQ_FOUR  = 3'd4;

    // Pending burst for one accepted byte: count of results still owed,
    // and the payload of the last of them (all earlier ones are U+FFFD).
    typedef struct packed {
        logic [LEN_W-1:0] cnt;
        logic [CP_W-1:0]  last_cp;
        logic             last_rep;
        logic             fin;
    } t_burst;

endpackage

// ----- hdl/utf8_strict_decoder.sv -----
// Strict UTF-8 decoder: bytes in, Unicode scalar values out, U+FFFD on error.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one raw byte per transaction,
//   with i_final_byte marking the last byte of a string. Output channel
//   (o_valid / i_ready) carries one code point per transaction, with flags:
//   o_replaced for U+FFFD substitutions, o_run_last on the last result caused
//   by one input byte, o_string_last on the final result of a string.
//   Each byte is decoded in the cycle it is accepted and its results land in
//   a burst register; the first result is visible in the cycle after acceptance.
//   A byte causes zero to four results, shown one per cycle while i_ready
//   is high. Throughput is one byte per cycle while each byte causes at most
//   one result and i_ready is high; a byte causing more holds o_ready low
//   until its last result is taken; the single burst register drains them.
//   Continuation and lead bytes that only extend a sequence give no result.
//   Reset (synchronous, active low) returns the decoder to idle and drops
//   any pending results. When the receiver stalls, the current result holds
//   and the input is taken only once the burst register frees up.
module utf8_strict_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u8sd_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_final_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u8sd_pkg::CP_W-1:0]     o_code_point,
    output logic                          o_replaced,
    output logic                          o_run_last,
    output logic                          o_string_last
);

    // Decoder state.
    logic [u8sd_pkg::CP_W-1:0]  r_pv,   n_pv;
    logic [u8sd_pkg::LEN_W-1:0] r_len,  n_len;
    logic [u8sd_pkg::LEN_W-1:0] r_gath, n_gath;

    // Result burst register.
    u8sd_pkg::t_burst r_burst, n_burst;

    logic in_fire;
    logic out_fire;

    // Fresh-byte decode (used when idle and after a broken sequence).
    logic                         f_emit;
    logic [u8sd_pkg::CP_W-1:0]    f_cp;
    logic                         f_rep;
    logic                         f_start;
    logic [u8sd_pkg::LEN_W-1:0]   f_len;
    logic [u8sd_pkg::CP_W-1:0]    f_pv;

    // Continuation path.
    logic [u8sd_pkg::CP_W-1:0]    c_pv;
    logic [u8sd_pkg::LEN_W-1:0]   c_gath;
    logic [u8sd_pkg::CP_W-1:0]    c_min;
    logic                         c_bad;
    logic                         is_cont;

    // Step results.
    u8sd_pkg::t_burst step;

    assign out_fire = o_valid && i_ready;
    // Take a byte when the burst register is empty or frees this cycle.
    assign o_ready  = (r_burst.cnt == '0) ||
                      ((r_burst.cnt == u8sd_pkg::LEN_W'(1)) && i_ready);
    assign in_fire  = i_valid && o_ready;

    always_comb begin
        f_emit  = 1'b1;
        f_cp    = u8sd_pkg::REPL_CP;
        f_rep   = 1'b1;
        f_start = 1'b0;
        f_len   = u8sd_pkg::SEQ_IDLE;
        f_pv    = '0;
        priority if (i_data_byte[7] == 1'b0) begin
            f_cp  = u8sd_pkg::CP_W'(i_data_byte);
            f_rep = 1'b0;
        end else if (i_data_byte[7:5] == 3'b110) begin
            f_len = u8sd_pkg::SEQ_TWO;
            f_pv  = u8sd_pkg::CP_W'(i_data_byte[4:0]);
        end else if (i_data_byte[7:4] == 4'b1110) begin
            f_len = u8sd_pkg::SEQ_THREE;
            f_pv  = u8sd_pkg::CP_W'(i_data_byte[3:0]);
        end else if (i_data_byte[7:3] == 5'b11110) begin
            f_len = u8sd_pkg::SEQ_FOUR;
            f_pv  = u8sd_pkg::CP_W'(i_data_byte[2:0]);
        end else begin
            f_len = u8sd_pkg::SEQ_IDLE;
        end
        // A valid lead starts a gather unless it ends the string.
        if (f_len != u8sd_pkg::SEQ_IDLE) begin
            f_emit  = i_final_byte;
            f_start = !i_final_byte;
        end
    end

    always_comb begin
        is_cont = (i_data_byte[7:6] == 2'b10);
        c_pv    = {r_pv[u8sd_pkg::CP_W-7:0], i_data_byte[5:0]};
        c_gath  = r_gath + u8sd_pkg::LEN_W'(1);
        unique case (r_len)
            u8sd_pkg::SEQ_TWO:   c_min = u8sd_pkg::MIN_CP_2;
            u8sd_pkg::SEQ_THREE: c_min = u8sd_pkg::MIN_CP_3;
            default:             c_min = u8sd_pkg::MIN_CP_4;
        endcase
        c_bad = (c_pv < c_min) || (c_pv > u8sd_pkg::MAX_CP) ||
                ((c_pv >= u8sd_pkg::SURR_LO) && (c_pv <= u8sd_pkg::SURR_HI));
    end

    // Next state and step results for the byte on the input.
    always_comb begin
        n_pv          = r_pv;
        n_len         = r_len;
        n_gath        = r_gath;
        step.cnt      = '0;
        step.last_cp  = u8sd_pkg::REPL_CP;
        step.last_rep = 1'b1;
        step.fin      = i_final_byte;
        priority if (r_len == u8sd_pkg::SEQ_IDLE || !is_cont) begin
            // Flush a broken gather, then decode the byte afresh.
            step.cnt = (r_len == u8sd_pkg::SEQ_IDLE) ? '0 : r_gath;
            if (f_emit) begin
                step.cnt      = step.cnt + u8sd_pkg::LEN_W'(1);
                step.last_cp  = f_cp;
                step.last_rep = f_rep;
            end
            n_pv   = f_start ? f_pv : '0;
            n_len  = f_start ? f_len : u8sd_pkg::SEQ_IDLE;
            n_gath = f_start ? u8sd_pkg::LEN_W'(1) : '0;
        end else if (c_gath >= r_len) begin
            if (c_bad) begin
                step.cnt = r_len;
            end else begin
                step.cnt      = u8sd_pkg::LEN_W'(1);
                step.last_cp  = c_pv;
                step.last_rep = 1'b0;
            end
            n_pv   = '0;
            n_len  = u8sd_pkg::SEQ_IDLE;
            n_gath = '0;
        end else if (i_final_byte) begin
            // Truncated: one replacement per gathered byte.
            step.cnt = c_gath;
            n_pv     = '0;
            n_len    = u8sd_pkg::SEQ_IDLE;
            n_gath   = '0;
        end else begin
            n_pv   = c_pv;
            n_gath = c_gath;
        end
    end

    // Load a new burst on accept, else drain one result per output transaction.
    always_comb begin
        n_burst = r_burst;
        if (out_fire) begin
            n_burst.cnt = r_burst.cnt - u8sd_pkg::LEN_W'(1);
        end
        if (in_fire) begin
            n_burst = step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= '0;
            r_len   <= u8sd_pkg::SEQ_IDLE;
            r_gath  <= '0;
            r_burst <= '0;
        end else begin
            if (in_fire) begin
                r_pv   <= n_pv;
                r_len  <= n_len;
                r_gath <= n_gath;
            end
            r_burst <= n_burst;
        end
    end

    // Every result but the last of a burst is a replacement.
    assign o_valid       = (r_burst.cnt != '0);
    assign o_run_last    = (r_burst.cnt == u8sd_pkg::LEN_W'(1));
    assign o_code_point  = o_run_last ? r_burst.last_cp : u8sd_pkg::REPL_CP;
    assign o_replaced    = o_run_last ? r_burst.last_rep : 1'b1;
    assign o_string_last = o_run_last && r_burst.fin;

endmodule

// ----- hdl/u8sd_checker.sv -----
// Port-level checker for the strict UTF-8 decoder, bound to the top level.
module u8sd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [u8sd_pkg::CP_W-1:0]     o_code_point,
    input logic                          o_replaced,
    input logic                          o_run_last,
    input logic                          o_string_last
);

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_point) &&
        $stable(o_replaced) && $stable(o_run_last) && $stable(o_string_last))
        else $error("stalled result changed");

    // Results ahead of the last one for a byte are replacements.
    a_early_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_run_last |-> o_replaced && (o_code_point == u8sd_pkg::REPL_CP))
        else $error("non-replacement before end of run");

    // End of string only on the last result of a byte.
    a_str_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_last |-> o_run_last)
        else $error("string end off run end");

    // Decoded values are scalar values.
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_replaced |-> (o_code_point <= u8sd_pkg::MAX_CP) &&
        ((o_code_point < u8sd_pkg::SURR_LO) || (o_code_point > u8sd_pkg::SURR_HI)))
        else $error("decoded value is not a scalar value");

endmodule

bind utf8_strict_decoder u8sd_checker u_u8sd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_code_point  (o_code_point),
    .o_replaced    (o_replaced),
    .o_run_last    (o_run_last),
    .o_string_last (o_string_last)
);

// ----- dv/utf8_strict_decoder_tb.sv -----
// Self-checking testbench for the strict UTF-8 decoder with U+FFFD replacement.

typedef struct packed {
    logic [u8sd_pkg::CP_W-1:0] code_point;
    logic                      replaced;
    logic                      run_last;
    logic                      string_last;
} t_cp_result;

// Track decoder state per accepted byte and hold the code points it still owes.
class cp_scoreboard;
    logic [u8sd_pkg::CP_W-1:0]  partial;
    logic [u8sd_pkg::LEN_W-1:0] seq_len;
    logic [u8sd_pkg::LEN_W-1:0] gathered;
    t_cp_result                 owed_q[$];
    int                         errors;

    function new();
        errors = 0;
        clear_gather();
    endfunction

    function void clear_gather();
        partial  = '0;
        seq_len  = u8sd_pkg::SEQ_IDLE;
        gathered = '0;
    endfunction

    function void owe(logic [u8sd_pkg::CP_W-1:0] cp, logic rep);
        t_cp_result r;
        r.code_point  = cp;
        r.replaced    = rep;
        r.run_last    = 1'b0;
        r.string_last = 1'b0;
        owed_q = {owed_q, r};
    endfunction

    // One replacement for the lead and one per gathered continuation.
    function void flush_gather();
        repeat (gathered) owe(u8sd_pkg::REPL_CP, 1'b1);
        clear_gather();
    endfunction

    function void start_gather(logic [u8sd_pkg::LEN_W-1:0] len,
                               logic [u8sd_pkg::CP_W-1:0] bits, logic fin);
        if (fin) begin
            owe(u8sd_pkg::REPL_CP, 1'b1);
        end else begin
            partial  = bits;
            seq_len  = len;
            gathered = 3'd1;
        end
    endfunction

    function void decode_fresh(logic [7:0] b, logic fin);
        casez (b)
            8'b0???_????: owe(u8sd_pkg::CP_W'(b), 1'b0);
            8'b110?_????: start_gather(u8sd_pkg::SEQ_TWO, u8sd_pkg::CP_W'(b[4:0]), fin);
            8'b1110_????: start_gather(u8sd_pkg::SEQ_THREE, u8sd_pkg::CP_W'(b[3:0]), fin);
            8'b1111_0???: start_gather(u8sd_pkg::SEQ_FOUR, u8sd_pkg::CP_W'(b[2:0]), fin);
            default:      owe(u8sd_pkg::REPL_CP, 1'b1);
        endcase
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
        int                        first;
        int                        last_idx;
        t_cp_result                r;
        logic [u8sd_pkg::CP_W-1:0] min_cp;
        first = owed_q.size();
        if (seq_len == u8sd_pkg::SEQ_IDLE) begin
            decode_fresh(b, fin);
        end else if (b[7:6] != 2'b10) begin
            flush_gather();
            decode_fresh(b, fin);
        end else begin
            partial  = {partial[u8sd_pkg::CP_W-7:0], b[5:0]};
            gathered = gathered + 1'b1;
            if (gathered >= seq_len) begin
                min_cp = (seq_len == u8sd_pkg::SEQ_TWO)   ? u8sd_pkg::MIN_CP_2 :
                         (seq_len == u8sd_pkg::SEQ_THREE) ? u8sd_pkg::MIN_CP_3 :
                                                            u8sd_pkg::MIN_CP_4;
                if (partial < min_cp || partial > u8sd_pkg::MAX_CP ||
                    (partial >= u8sd_pkg::SURR_LO && partial <= u8sd_pkg::SURR_HI)) begin
                    repeat (seq_len) owe(u8sd_pkg::REPL_CP, 1'b1);
                end else begin
                    owe(partial, 1'b0);
                end
                clear_gather();
            end else if (fin) begin
                flush_gather();
            end
        end
        if (fin) clear_gather();
        if (owed_q.size() > first) begin
            last_idx         = owed_q.size() - 1;
            r                = owed_q[last_idx];
            r.run_last       = 1'b1;
            r.string_last    = fin;
            owed_q[last_idx] = r;
        end
    endfunction

    function void check_result(t_cp_result got);
        t_cp_result want;
        if (owed_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result cp=%h rep=%b run_last=%b string_last=%b",
                         got.code_point, got.replaced, got.run_last, got.string_last);
            return;
        end
        want = owed_q.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: expected cp=%h rep=%b rl=%b sl=%b, got cp=%h rep=%b rl=%b sl=%b",
                         want.code_point, want.replaced, want.run_last, want.string_last,
                         got.code_point, got.replaced, got.run_last, got.string_last);
        end
    endfunction

    function int pending();
        return owed_q.size();
    endfunction
endclass

module utf8_strict_decoder_tb;

    typedef logic [7:0] t_byte_q[$];

    localparam int CLK_HALF       = 5;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 8;

    // Directed bytes; bit 8 is the final-byte flag of the transaction.
    localparam logic [8:0] DIRECTED [26] = '{
        9'h000, 9'h17F,                 // ASCII extremes, the second ends a string
        9'h0E2, 9'h082, 9'h0AC,         // three-byte sequence (euro sign)
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, // highest scalar value U+10FFFF
        9'h0FF, 9'h080,                 // bad leads: invalid byte, stray continuation
        9'h0E2, 9'h082, 9'h041,         // gather broken by an ASCII byte
        9'h0C0, 9'h080,                 // overlong two-byte form
        9'h0ED, 9'h0A0, 9'h080,         // surrogate U+D800
        9'h0F4, 9'h090, 9'h080, 9'h080, // above U+10FFFF
        9'h0E2, 9'h182,                 // string truncated mid-sequence
        9'h1F0                          // lead byte that is itself final
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [u8sd_pkg::BYTE_W-1:0] i_data_byte;
    logic                        i_final_byte;
    logic                        o_valid;
    logic                        i_ready;
    logic [u8sd_pkg::CP_W-1:0]   o_code_point;
    logic                        o_replaced;
    logic                        o_run_last;
    logic                        o_string_last;

    logic              rx_hold_req = 1'b0;
    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    int                sent = 0;
    cp_scoreboard      sb;

    utf8_strict_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_point  (o_code_point),
        .o_replaced    (o_replaced),
        .o_run_last    (o_run_last),
        .o_string_last (o_string_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Hard stop in case the decoder hangs or stops producing results.
    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: toggle ready at random; on request, hold ready low for a long
    // stretch so the burst register fills and the input channel stalls.
    initial begin : rx_driver
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req <= 1'b0;
                i_ready     <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Check every output transaction against the oldest owed code point.
    // All drivers use nonblocking writes, so these are pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_code_point, o_replaced, o_run_last, o_string_last});
    end

    // Offer one byte, with optional idle cycles first; hold valid and payload
    // until the transaction completes, then record it in the scoreboard.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b, fin);
        sent++;
    endtask

    // Drop valid and wait until every owed code point has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Encode one character: mostly well-formed, the rest malformed on purpose.
    function automatic t_byte_q random_char();
        t_byte_q                   q;
        int unsigned               pick;
        int unsigned               len;
        logic                      chop;
        logic [u8sd_pkg::CP_W-1:0] cp;
        pick = $urandom_range(99);
        chop = 1'b0;
        if (pick < 30) begin
            len = 1;
            cp  = u8sd_pkg::CP_W'($urandom_range(32'h7F));
        end else if (pick < 45) begin
            len = 2;
            cp  = u8sd_pkg::CP_W'($urandom_range(32'h7FF, 32'h80));
        end else if (pick < 60) begin
            len = 3;
            cp  = u8sd_pkg::CP_W'($urandom_range(32'hFFFF, 32'h800));
            // steer clear of the surrogate block
            if (cp >= u8sd_pkg::SURR_LO && cp <= u8sd_pkg::SURR_HI) cp ^= 21'h2000;
        end else if (pick < 72) begin
            len = 4;
            cp  = u8sd_pkg::CP_W'($urandom_range(32'h10FFFF, 32'h10000));
        end else if (pick < 78) begin
            q = {q, 8'($urandom_range(255))};
            return q;
        end else if (pick < 82) begin
            q = {q, 8'($urandom_range(8'hBF, 8'h80))};
            return q;
        end else if (pick < 87) begin
            // overlong: value fits a shorter form
            len = $urandom_range(4, 2);
            case (len)
                2:       cp = u8sd_pkg::CP_W'($urandom_range(32'h7F));
                3:       cp = u8sd_pkg::CP_W'($urandom_range(32'h7FF));
                default: cp = u8sd_pkg::CP_W'($urandom_range(32'hFFFF));
            endcase
        end else if (pick < 91) begin
            len = 3;
            cp  = u8sd_pkg::CP_W'($urandom_range(32'hDFFF, 32'hD800));
        end else if (pick < 95) begin
            len = 4;
            cp  = u8sd_pkg::CP_W'($urandom_range(32'h1FFFFF, 32'h110000));
        end else begin
            // lead plus too few continuations
            len  = $urandom_range(4, 2);
            cp   = u8sd_pkg::CP_W'($urandom_range(32'h1FFFFF));
            chop = 1'b1;
        end
        case (len)
            1: q = {q, cp[7:0]};
            2: begin
                q = {q, {3'b110, cp[10:6]}};
                q = {q, {2'b10, cp[5:0]}};
            end
            3: begin
                q = {q, {4'b1110, cp[15:12]}};
                q = {q, {2'b10, cp[11:6]}};
                q = {q, {2'b10, cp[5:0]}};
            end
            default: begin
                q = {q, {5'b11110, cp[20:18]}};
                q = {q, {2'b10, cp[17:12]}};
                q = {q, {2'b10, cp[11:6]}};
                q = {q, {2'b10, cp[5:0]}};
            end
        endcase
        if (chop) repeat ($urandom_range(len - 1, 1)) void'(q.pop_back());
        return q;
    endfunction

    // Send a short string; flag its last byte as final.
    task automatic send_string(input int n_chars);
        t_byte_q str_q;
        repeat (n_chars) str_q = {str_q, random_char()};
        foreach (str_q[k]) send_byte(str_q[k], k == str_q.size() - 1);
    endtask

    initial begin : stimulus
        sb = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= '0;
        i_final_byte <= 1'b0;
        tx_idle_pct  = 18;
        rx_idle_pct  = 64;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases, then a sparse sender against a slow receiver.
        foreach (DIRECTED[k]) send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
        while (sent < 170) send_string($urandom_range(6, 1));

        // Pause the sender until the decoder has emptied out.
        wait_drained();

        // Swap roles: slow sender, eager receiver.
        tx_idle_pct = 64;
        rx_idle_pct = 18;
        while (sent < 290) send_string($urandom_range(6, 1));

        // Full rate both sides, opened by a long receiver hold-off.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req <= 1'b1;
        while (sent < 410) send_string($urandom_range(6, 1));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
